// File: src/rba_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the refcounted block allocator.
// No dependencies.
package rba_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_BLOCKS_DEF  = 256;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int POOL_W   = 9;
    localparam int CMD_W    = 3;
    localparam int BLK_W    = 8;
    localparam int SHARE_W  = 16;
    localparam int FAIL_W   = 32;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [POOL_W-1:0] POOL_RESET = 9'd256;

    // Register index, taken from paddr[2]
    localparam logic REG_POOL_BLOCKS = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE          = 3'd0,
        CMD_SEAL             = 3'd1,
        CMD_RETAIN           = 3'd2,
        CMD_RELEASE_SHARED   = 3'd3,
        CMD_RELEASE_WRITABLE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_MISUSE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_GRANT = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [BLK_W-1:0] block_index;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [BLK_W-1:0]    granted_block;
        logic                block_freed;
        logic [SHARE_W-1:0]  share_count;
        logic [POOL_W-1:0]   blocks_in_use;
        logic [POOL_W-1:0]   blocks_free;
        logic [POOL_W-1:0]   peak_in_use;
        logic [FAIL_W-1:0]   failed_acquires;
    } rsp_t;

endpackage

// File: src/refcounted_block_allocator.sv
`timescale 1ns / 1ps
// Refcounted block allocator: LIFO free stack plus per-block share counts.
// An acquire steps through idle, grant and exec; other commands skip grant. A new
// request is taken only once back in idle; exec waits while the last result is
// held. Each command is a read-modify-write through the registered-read count and
// stack memories. Reset and any pool_blocks write run a clearing pass over all
// MAX_BLOCKS entries, zeroing counts and refilling the stack; no request is taken meanwhile.
// Depends on rba_pkg and rba_ram.
module refcounted_block_allocator #(
    parameter int MAX_BLOCKS  = rba_pkg::MAX_BLOCKS_DEF,
    parameter int COUNT_WIDTH = rba_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          req_valid,
    output logic                          req_ready,
    input  rba_pkg::req_t                 req,
    // result channel
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output rba_pkg::rsp_t                 rsp,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rba_pkg::PADDR_W-1:0]   paddr,
    input  logic [rba_pkg::PDATA_W-1:0]   pwdata,
    output logic [rba_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(MAX_BLOCKS - 1);

    // Clamp a written pool size: zero acts as one, anything above MAX_BLOCKS as MAX_BLOCKS.
    function automatic logic [rba_pkg::POOL_W-1:0] pool_clamp(
        input logic [rba_pkg::POOL_W-1:0] v
    );
        logic [rba_pkg::POOL_W-1:0] r;
        if (v == '0)
        begin
            r = rba_pkg::POOL_W'(1);
        end
        else if (32'(v) > 32'(MAX_BLOCKS))
        begin
            r = rba_pkg::POOL_W'(MAX_BLOCKS);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    rba_pkg::state_t               state_reg,   state_next;
    logic [IDX_W-1:0]              clr_reg,     clr_next;
    logic [rba_pkg::POOL_W-1:0]    pool_reg,    pool_next;
    logic [rba_pkg::POOL_W-1:0]    depth_reg,   depth_next;
    logic [rba_pkg::POOL_W-1:0]    in_use_reg,  in_use_next;
    logic [rba_pkg::POOL_W-1:0]    peak_reg,    peak_next;
    logic [rba_pkg::FAIL_W-1:0]    fail_reg,    fail_next;
    logic [rba_pkg::CMD_W-1:0]     cmd_reg,     cmd_next;
    logic [rba_pkg::BLK_W-1:0]     blk_reg,     blk_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    rba_pkg::rsp_t                 rsp_reg,     rsp_next;

    // Memory ports
    logic                          cnt_we, cnt_re;
    logic [IDX_W-1:0]              cnt_waddr, cnt_raddr;
    logic [COUNT_WIDTH-1:0]        cnt_wdata, cnt_rdata;
    logic                          stk_we, stk_re;
    logic [IDX_W-1:0]              stk_waddr, stk_raddr;
    logic [IDX_W-1:0]              stk_wdata, stk_rdata, stk_init;

    // Execute-stage results
    logic [rba_pkg::POOL_W-1:0]    pool_n;
    logic                          cfg_wr;
    logic                          exec_go;
    logic                          can_free;
    logic                          blk_ok;
    logic                          cnt_we_x;
    logic [COUNT_WIDTH-1:0]        cnt_new_x;
    logic                          push_x;
    logic [rba_pkg::POOL_W-1:0]    depth_x, in_use_x, peak_x;
    logic [rba_pkg::FAIL_W-1:0]    fail_x;
    rba_pkg::rsp_t                 rsp_x;
    logic [31:0]                   init_wide;

    assign pool_n = pool_clamp(pool_reg);

    // ------------------------------------------------------------------
    // Configuration port: always ready, one register selected by paddr[2]
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == rba_pkg::REG_POOL_BLOCKS);
    assign prdata = (paddr[2] == rba_pkg::REG_POOL_BLOCKS)
                  ? rba_pkg::PDATA_W'(pool_reg) : '0;

    // ------------------------------------------------------------------
    // Handshake: take a request only when idle and no reinit lands this cycle
    // ------------------------------------------------------------------
    assign req_ready = (state_reg == rba_pkg::S_IDLE) && !cfg_wr;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Execute may finish once the output register is free or being drained
    assign exec_go = (state_reg == rba_pkg::S_EXEC) && (!rsp_valid_reg || rsp_ready);

    // ------------------------------------------------------------------
    // Memory addressing
    // ------------------------------------------------------------------
    // Clearing pass refills the stack with descending numbers, zero on top
    assign init_wide = (32'(clr_reg) < 32'(pool_n))
                     ? (32'(pool_n) - 32'd1 - 32'(clr_reg)) : 32'd0;
    assign stk_init  = IDX_W'(init_wide);

    always_comb
    begin
        if (state_reg == rba_pkg::S_CLEAR)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_reg;
            cnt_wdata = '0;
            stk_we    = 1'b1;
            stk_waddr = clr_reg;
            stk_wdata = stk_init;
        end
        else
        begin
            cnt_we    = exec_go && cnt_we_x;
            cnt_waddr = IDX_W'(blk_reg);
            cnt_wdata = cnt_new_x;
            stk_we    = exec_go && push_x;
            stk_waddr = IDX_W'(depth_reg);
            stk_wdata = IDX_W'(blk_reg);
        end
    end

    // Idle: read the addressed count and the stack top together.
    // Grant: chase the popped block number into the count memory.
    assign stk_re    = req_valid && req_ready;
    assign stk_raddr = IDX_W'(depth_reg - rba_pkg::POOL_W'(1));
    assign cnt_re    = (req_valid && req_ready) || (state_reg == rba_pkg::S_GRANT);
    assign cnt_raddr = (state_reg == rba_pkg::S_GRANT) ? stk_rdata : IDX_W'(req.block_index);

    rba_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_BLOCKS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    rba_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // ------------------------------------------------------------------
    // Execute: modify the count read back, decide push/pop, build the result.
    // A command rejected as misuse leaves all state as it was; an empty acquire only counts a failure.
    // ------------------------------------------------------------------
    assign can_free = (in_use_reg != '0) && (depth_reg < pool_n);
    assign blk_ok   = (rba_pkg::POOL_W'(blk_reg) < pool_n);

    always_comb
    begin
        depth_x   = depth_reg;
        in_use_x  = in_use_reg;
        peak_x    = peak_reg;
        fail_x    = fail_reg;
        cnt_we_x  = 1'b0;
        cnt_new_x = cnt_rdata;
        push_x    = 1'b0;
        rsp_x     = '0;
        rsp_x.status = rba_pkg::ST_OK;

        if (cmd_reg == rba_pkg::CMD_ACQUIRE)
        begin
            if (depth_reg == '0)
            begin
                rsp_x.status = rba_pkg::ST_EMPTY;
                if (fail_reg != '1)
                begin
                    fail_x = fail_reg + rba_pkg::FAIL_W'(1);
                end
            end
            else
            begin
                // Pop: stack top was read in idle, its count in grant
                depth_x  = depth_reg - rba_pkg::POOL_W'(1);
                in_use_x = in_use_reg + rba_pkg::POOL_W'(1);
                if (in_use_x > peak_reg)
                begin
                    peak_x = in_use_x;
                end
                rsp_x.granted_block = rba_pkg::BLK_W'(stk_rdata);
                rsp_x.share_count   = rba_pkg::SHARE_W'(cnt_rdata);
            end
        end
        else if (!(cmd_reg inside {[rba_pkg::CMD_SEAL:rba_pkg::CMD_RELEASE_WRITABLE]}) || !blk_ok)
        begin
            rsp_x.status = rba_pkg::ST_MISUSE;
        end
        else
        begin
            case (cmd_reg)
                rba_pkg::CMD_SEAL:
                begin
                    if (cnt_rdata != '0)
                    begin
                        rsp_x.status = rba_pkg::ST_MISUSE;
                    end
                    else
                    begin
                        cnt_new_x = COUNT_WIDTH'(1);
                        cnt_we_x  = 1'b1;
                    end
                end
                rba_pkg::CMD_RETAIN:
                begin
                    // Saturated count is misuse, not a wrap
                    if (cnt_rdata == '0 || cnt_rdata == CNT_MAX)
                    begin
                        rsp_x.status = rba_pkg::ST_MISUSE;
                    end
                    else
                    begin
                        cnt_new_x = cnt_rdata + COUNT_WIDTH'(1);
                        cnt_we_x  = 1'b1;
                    end
                end
                rba_pkg::CMD_RELEASE_SHARED:
                begin
                    if (cnt_rdata == '0)
                    begin
                        rsp_x.status = rba_pkg::ST_MISUSE;
                    end
                    else if (cnt_rdata == COUNT_WIDTH'(1))
                    begin
                        // Last share drops: free the block if the stack can take it
                        if (!can_free)
                        begin
                            rsp_x.status = rba_pkg::ST_MISUSE;
                        end
                        else
                        begin
                            cnt_new_x = '0;
                            cnt_we_x  = 1'b1;
                            push_x    = 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_new_x = cnt_rdata - COUNT_WIDTH'(1);
                        cnt_we_x  = 1'b1;
                    end
                end
                rba_pkg::CMD_RELEASE_WRITABLE:
                begin
                    if (cnt_rdata != '0 || !can_free)
                    begin
                        rsp_x.status = rba_pkg::ST_MISUSE;
                    end
                    else
                    begin
                        push_x = 1'b1;
                    end
                end
                default:
                begin
                    rsp_x.status = rba_pkg::ST_MISUSE;
                end
            endcase

            if (push_x)
            begin
                depth_x  = depth_reg + rba_pkg::POOL_W'(1);
                in_use_x = in_use_reg - rba_pkg::POOL_W'(1);
            end
            rsp_x.block_freed = push_x;
            rsp_x.share_count = rba_pkg::SHARE_W'(cnt_new_x);
        end

        rsp_x.blocks_in_use   = in_use_x;
        rsp_x.blocks_free     = depth_x;
        rsp_x.peak_in_use     = peak_x;
        rsp_x.failed_acquires = fail_x;
    end

    // ------------------------------------------------------------------
    // Sequencer and next-state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pool_next      = pool_reg;
        depth_next     = depth_reg;
        in_use_next    = in_use_reg;
        peak_next      = peak_reg;
        fail_next      = fail_reg;
        cmd_next       = cmd_reg;
        blk_next       = blk_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        // Drop the held result once taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            rba_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = rba_pkg::S_IDLE;
                end
            end
            rba_pkg::S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    cmd_next   = req.command;
                    blk_next   = req.block_index;
                    state_next = (req.command == rba_pkg::CMD_ACQUIRE)
                               ? rba_pkg::S_GRANT : rba_pkg::S_EXEC;
                end
            end
            rba_pkg::S_GRANT:
            begin
                state_next = rba_pkg::S_EXEC;
            end
            rba_pkg::S_EXEC:
            begin
                // Hold here while the previous result still waits
                if (exec_go)
                begin
                    depth_next     = depth_x;
                    in_use_next    = in_use_x;
                    peak_next      = peak_x;
                    fail_next      = fail_x;
                    rsp_next       = rsp_x;
                    rsp_valid_next = 1'b1;
                    state_next     = rba_pkg::S_IDLE;
                end
            end
            default:
            begin
                clr_next   = '0;
                state_next = rba_pkg::S_CLEAR;
            end
        endcase

        // Pool size write: reinitialize counters and restart the clearing pass
        if (cfg_wr)
        begin
            pool_next   = pwdata[rba_pkg::POOL_W-1:0];
            depth_next  = pool_clamp(pwdata[rba_pkg::POOL_W-1:0]);
            in_use_next = '0;
            peak_next   = '0;
            fail_next   = '0;
            clr_next    = '0;
            state_next  = rba_pkg::S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rba_pkg::S_CLEAR;
            clr_reg       <= '0;
            pool_reg      <= rba_pkg::POOL_RESET;
            depth_reg     <= pool_clamp(rba_pkg::POOL_RESET);
            in_use_reg    <= '0;
            peak_reg      <= '0;
            fail_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pool_reg      <= pool_next;
            depth_reg     <= depth_next;
            in_use_reg    <= in_use_next;
            peak_reg      <= peak_next;
            fail_reg      <= fail_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        blk_reg <= blk_next;
        rsp_reg <= rsp_next;
    end

endmodule

// File: src/rba_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
